/* rtl/core/queued_linear_move_interpolator_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef QUEUED_LINEAR_MOVE_INTERPOLATOR_ASSERT_SVH
`define QUEUED_LINEAR_MOVE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QLMI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qlmi: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define QLMI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qlmi: next-cycle property failed");

`endif

/* rtl/core/qlmi_pkg.sv */
package qlmi_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int POS_W   = 24;
  localparam int TIME_W  = 24;
  localparam int DELTA_W = 20;
  localparam int FRAC_W  = 17;
  localparam int QUOT_W  = 16;
  localparam int DIST_W  = POS_W + 1;
  localparam int SCL_W   = POS_W + 2;

  localparam int DIV_STEPS = QUOT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int IN_W  = 120;
  localparam int OUT_W = 64;

  typedef enum logic [2:0] {
    FN_PUSH   = 3'd0,
    FN_TICK   = 3'd1,
    FN_SKIP   = 3'd2,
    FN_RENDER = 3'd3,
    FN_SYNC   = 3'd4
  } func_t;

  typedef enum logic {
    CFG_START_X = 1'b0,
    CFG_START_Y = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_MUL,
    S_SUM,
    S_SKIP_RD,
    S_SKIP_AP,
    S_RMUL,
    S_RSUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } target_t;

  typedef struct packed {
    logic [TIME_W-1:0] dur;
    logic [7:0]        anim;
    logic              keep_x;
    logic              keep_y;
  } timing_t;

endpackage

/* rtl/core/qlmi_ram.sv */
module qlmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/qlmi_div.sv */
module qlmi_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qlmi_pkg::TIME_W-1:0] dividend,
  input  logic [qlmi_pkg::TIME_W-1:0] divisor,
  output logic [qlmi_pkg::QUOT_W-1:0] quot,
  output logic                        done
);
  import qlmi_pkg::*;

  logic [TIME_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [TIME_W:0]      shifted;
  logic                 ge;
  logic [TIME_W-1:0]    rem_next;

  // One quotient bit per cycle; remainder stays below the divisor
  always_comb begin
    shifted  = {rem, 1'b0};
    ge       = shifted >= {1'b0, divisor};
    rem_next = ge ? TIME_W'(shifted - {1'b0, divisor}) : shifted[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/qlmi_scale.sv */
module qlmi_scale (
  input  logic                               clk,
  input  logic signed [qlmi_pkg::DIST_W-1:0] span,
  input  logic        [qlmi_pkg::FRAC_W-1:0] frac,
  output logic signed [qlmi_pkg::SCL_W-1:0]  scaled
);
  import qlmi_pkg::*;

  localparam int PROD_W = DIST_W + FRAC_W + 1;

  logic signed [PROD_W-1:0] prod;

  // Register the product, then round half up and drop the fraction
  always_ff @(posedge clk) begin
    prod <= PROD_W'(span) * PROD_W'($signed({1'b0, frac}));
  end

  assign scaled = SCL_W'((prod + PROD_W'(32768)) >>> 16);

endmodule

/* rtl/core/queued_linear_move_interpolator.sv */
// channel  direction  handshake          payload
// s_       in         s_tvalid/s_tready  s_tdata fields, s_tuser = func
// m_       out        m_tvalid/m_tready  m_tdata result fields
// cfg_     in         cfg_valid/cfg_ready cfg_addr register, cfg_data value
//
// One item at a time. Push, sync and unused codes go straight to done; a
// starting tick reads the queue head; an active tick reads it, forms progress
// in the shift-subtract divider (16 quotient bits and a done step; skipped
// when progress is already one), then multiplies and sums; render multiplies
// and sums; skip reads and applies each queued action in turn.
// Reset is synchronous; the queue memories need no clearing pass.
// A waiting result holds only its output register: the next word is accepted
// and held at its last step until the output register frees.
module queued_linear_move_interpolator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // target_x, target_y, keep_x, keep_y, duration, anim_id, tick_delta,
  // frame_fraction, zero fill
  input  logic [qlmi_pkg::IN_W-1:0]        s_tdata,
  // func
  input  logic [2:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pos_x, pos_y, current_anim, busy_res, dropped, queued, zero fill
  output logic [qlmi_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_addr,
  input  logic [qlmi_pkg::POS_W-1:0]       cfg_data
);
  import qlmi_pkg::*;

  state_t state, state_next;

  // input fields
  func_t                     in_fn;
  logic signed [POS_W-1:0]   in_tx, in_ty;
  logic                      in_kx, in_ky;
  logic [TIME_W-1:0]         in_dur;
  logic [7:0]                in_anim;
  logic [DELTA_W-1:0]        in_delta;
  logic [FRAC_W-1:0]         in_frac;

  assign in_fn    = func_t'(s_tuser);
  assign in_tx    = s_tdata[23:0];
  assign in_ty    = s_tdata[47:24];
  assign in_kx    = s_tdata[48];
  assign in_ky    = s_tdata[49];
  assign in_dur   = s_tdata[73:50];
  assign in_anim  = s_tdata[81:74];
  assign in_delta = s_tdata[101:82];
  assign in_frac  = s_tdata[118:102];

  // architectural state
  logic [PTR_W-1:0]        rd_ptr, wr_ptr;
  logic [CNT_W-1:0]        count;
  logic signed [POS_W-1:0] pos_x, pos_y, nxt_x, nxt_y, prv_x, prv_y;
  logic [TIME_W-1:0]       elapsed;
  logic                    acting;
  logic [7:0]              anim_now;

  // per-item working registers
  func_t                   fn;
  logic                    drop;
  logic                    tick_run;
  logic                    fin;
  logic [FRAC_W-1:0]       frac;
  logic signed [POS_W-1:0] rend_x, rend_y;

  logic s_acc, cfg_acc, out_free;
  logic full, empty, last;
  logic [TIME_W:0]    e_sum;
  logic [TIME_W-1:0]  e_sat;
  logic [PTR_W-1:0]   rd_inc, wr_inc;

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign last  = (count == CNT_W'(1));
  assign e_sum = {1'b0, elapsed} + (TIME_W+1)'(in_delta);
  assign e_sat = e_sum[TIME_W] ? TIME_MAX : e_sum[TIME_W-1:0];
  assign rd_inc = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_inc = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;

  // queue memories
  target_t tgt_rd, tgt_wd;
  timing_t tim_rd, tim_wd;
  logic    q_we;
  logic [PTR_W-1:0] q_waddr;
  logic    push_wr, start_wb;
  logic signed [POS_W-1:0] res_x, res_y;

  assign push_wr  = s_acc && (in_fn == FN_PUSH) && !full;
  assign start_wb = (state == S_READ) && !tick_run;
  assign res_x    = tim_rd.keep_x ? pos_x : tgt_rd.x;
  assign res_y    = tim_rd.keep_y ? pos_y : tgt_rd.y;
  assign q_we     = push_wr || start_wb;
  assign q_waddr  = push_wr ? wr_ptr : rd_ptr;

  always_comb begin
    if (push_wr) begin
      tgt_wd = '{y: in_ty, x: in_tx};
      tim_wd = '{dur: in_dur, anim: in_anim, keep_x: in_kx, keep_y: in_ky};
    end else begin
      tgt_wd = '{y: res_y, x: res_x};
      tim_wd = '{dur: tim_rd.dur, anim: tim_rd.anim, keep_x: 1'b0, keep_y: 1'b0};
    end
  end

  qlmi_ram #(.WIDTH($bits(target_t)), .DEPTH(QUEUE_DEPTH)) u_tgt_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (tgt_wd),
    .raddr (rd_ptr),
    .rdata (tgt_rd)
  );

  qlmi_ram #(.WIDTH($bits(timing_t)), .DEPTH(QUEUE_DEPTH)) u_tim_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (tim_wd),
    .raddr (rd_ptr),
    .rdata (tim_rd)
  );

  // progress divider
  logic              div_start, div_done;
  logic [QUOT_W-1:0] div_quot;
  logic              reached;

  assign reached   = elapsed >= tim_rd.dur;
  assign div_start = (state == S_READ) && tick_run && !reached;

  qlmi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (tim_rd.dur),
    .quot     (div_quot),
    .done     (div_done)
  );

  // scaling units, shared by tick and render
  logic signed [DIST_W-1:0] dist_x, dist_y;
  logic signed [SCL_W-1:0]  scl_x, scl_y;

  always_comb begin
    if (state == S_RMUL) begin
      dist_x = DIST_W'(nxt_x) - DIST_W'(prv_x);
      dist_y = DIST_W'(nxt_y) - DIST_W'(prv_y);
    end else begin
      dist_x = DIST_W'(tgt_rd.x) - DIST_W'(pos_x);
      dist_y = DIST_W'(tgt_rd.y) - DIST_W'(pos_y);
    end
  end

  qlmi_scale u_scale_x (.clk(clk), .span(dist_x), .frac(frac), .scaled(scl_x));
  qlmi_scale u_scale_y (.clk(clk), .span(dist_y), .frac(frac), .scaled(scl_y));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          priority case (in_fn)
            FN_TICK:   state_next = empty ? S_DONE : S_READ;
            FN_SKIP:   state_next = empty ? S_DONE : S_SKIP_RD;
            FN_RENDER: state_next = S_RMUL;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_READ:    state_next = !tick_run ? S_DONE : (reached ? S_MUL : S_DIV);
      S_DIV:     state_next = div_done ? S_MUL : S_DIV;
      S_MUL:     state_next = S_SUM;
      S_SUM:     state_next = S_DONE;
      S_SKIP_RD: state_next = S_SKIP_AP;
      S_SKIP_AP: state_next = last ? S_DONE : S_SKIP_RD;
      S_RMUL:    state_next = S_RSUM;
      S_RSUM:    state_next = S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // architectural state and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      count    <= '0;
      pos_x    <= '0;
      pos_y    <= '0;
      nxt_x    <= '0;
      nxt_y    <= '0;
      prv_x    <= '0;
      prv_y    <= '0;
      elapsed  <= '0;
      acting   <= 1'b0;
      anim_now <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_START_X: begin
            pos_x <= cfg_data;
            nxt_x <= cfg_data;
            prv_x <= cfg_data;
          end
          CFG_START_Y: begin
            pos_y <= cfg_data;
            nxt_y <= cfg_data;
            prv_y <= cfg_data;
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            priority case (in_fn)
              FN_PUSH: begin
                if (!full) begin
                  wr_ptr <= wr_inc;
                  count  <= count + 1'b1;
                end
              end
              FN_TICK: begin
                prv_x <= nxt_x;
                prv_y <= nxt_y;
                if (acting && !empty) begin
                  elapsed <= e_sat;
                end else if (acting) begin
                  acting <= 1'b0;
                end
              end
              FN_SKIP: begin
                acting  <= 1'b0;
                elapsed <= '0;
                if (empty) begin
                  prv_x <= nxt_x;
                  prv_y <= nxt_y;
                end
              end
              FN_SYNC: begin
                prv_x <= nxt_x;
                prv_y <= nxt_y;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (!tick_run) begin
            anim_now <= tim_rd.anim;
            acting   <= 1'b1;
            elapsed  <= '0;
          end
        end
        S_SUM: begin
          if (fin) begin
            pos_x  <= tgt_rd.x;
            pos_y  <= tgt_rd.y;
            nxt_x  <= tgt_rd.x;
            nxt_y  <= tgt_rd.y;
            acting <= 1'b0;
            rd_ptr <= rd_inc;
            count  <= count - 1'b1;
          end else begin
            nxt_x <= pos_x + scl_x[POS_W-1:0];
            nxt_y <= pos_y + scl_y[POS_W-1:0];
          end
        end
        S_SKIP_AP: begin
          anim_now <= tim_rd.anim;
          pos_x    <= res_x;
          pos_y    <= res_y;
          nxt_x    <= res_x;
          nxt_y    <= res_y;
          rd_ptr   <= rd_inc;
          count    <= count - 1'b1;
          if (last) begin
            prv_x <= res_x;
            prv_y <= res_y;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      fn       <= in_fn;
      drop     <= (in_fn == FN_PUSH) && full;
      tick_run <= acting && !empty;
      frac     <= (in_frac > FRAC_ONE) ? FRAC_ONE : in_frac;
    end
    if (state == S_READ) begin
      fin  <= reached;
      frac <= FRAC_ONE;
    end
    if (div_done) begin
      frac <= FRAC_W'(div_quot);
    end
    if (state == S_RSUM) begin
      rend_x <= prv_x + scl_x[POS_W-1:0];
      rend_y <= prv_y + scl_y[POS_W-1:0];
    end
  end

  // output register
  logic signed [POS_W-1:0] out_x, out_y;

  assign out_x = (fn == FN_RENDER) ? rend_x : nxt_x;
  assign out_y = (fn == FN_RENDER) ? rend_y : nxt_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {1'b0, count, drop, acting, anim_now, out_y, out_x};
    end
  end

endmodule

/* rtl/core/qlmi_check.sv */
`include "queued_linear_move_interpolator_assert.svh"

module qlmi_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result word holds
  `QLMI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A drop only happens on a full queue
  `QLMI_ASSERT_NOW(a_drop_full, clk, rst, m_tvalid && m_tdata[57], m_tdata[62:58] == 5'd16)

  // An action in progress always has its entry queued
  `QLMI_ASSERT_NOW(a_busy_queued, clk, rst, m_tvalid && m_tdata[56], m_tdata[62:58] != 5'd0)

  // Configuration and items never land in the same cycle
  `QLMI_ASSERT_NOW(a_cfg_excl, clk, rst, cfg_valid && cfg_ready, !(s_tvalid && s_tready))

endmodule

bind queued_linear_move_interpolator qlmi_check u_qlmi_check (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

/* test/tb_queued_linear_move_interpolator.sv */
module tb_queued_linear_move_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  import qlmi_pkg::*;

  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 800;
  localparam longint P_MAX = 64'sd8388607;
  localparam longint P_MIN = -64'sd8388608;

  typedef struct {
    logic [2:0]  fn;
    logic [23:0] tx;
    logic [23:0] ty;
    logic        kx;
    logic        ky;
    logic [23:0] dur;
    logic [7:0]  anim;
    logic [19:0] delta;
    logic [16:0] frac;
  } move_cmd_t;

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic [7:0]  anim;
    logic        busy;
    logic        drop;
    logic [4:0]  cnt;
  } move_res_t;

  typedef struct {
    move_cmd_t cmd;
    bit        lit;
    move_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_addr = 1'b0;
  logic [POS_W-1:0] cfg_data = '0;

  queued_linear_move_interpolator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  longint      pos_x, pos_y, nxt_x, nxt_y, prv_x, prv_y;
  longint      qx[QUEUE_DEPTH], qy[QUEUE_DEPTH];
  int unsigned qdur[QUEUE_DEPTH];
  logic [7:0]  qanim[QUEUE_DEPTH];
  bit          qkx[QUEUE_DEPTH], qky[QUEUE_DEPTH];
  int unsigned rd_ptr, wr_ptr, held;
  int unsigned elapsed_us;
  bit          acting;
  logic [7:0]  anim_now;

  move_res_t expected_moves[$];
  int errors = 0;
  int burst_left = 0;
  bit no_gaps = 0;
  int hold_cycles = 0;
  int cycles = 0;

  function automatic longint sext24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  // product of a distance and a Q1.16 fraction, rounded half up
  function automatic longint scale_frac(longint d, longint f);
    return (d * f + 32768) >>> 16;
  endfunction

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  task automatic start_head();
    anim_now = qanim[rd_ptr];
    if (qkx[rd_ptr]) begin qx[rd_ptr] = pos_x; qkx[rd_ptr] = 0; end
    if (qky[rd_ptr]) begin qy[rd_ptr] = pos_y; qky[rd_ptr] = 0; end
  endtask

  task automatic pop_head();
    rd_ptr = next_slot(rd_ptr);
    held--;
  endtask

  // advance the predictor by one word and return the word it should report
  task automatic predict_move(input move_cmd_t c, output move_res_t r);
    longint ox, oy, p, f;
    longint unsigned e;
    bit drop;
    drop = 0;
    ox = nxt_x;
    oy = nxt_y;
    case (c.fn)
      FN_PUSH: begin
        if (held >= QUEUE_DEPTH) drop = 1;
        else begin
          qx[wr_ptr] = sext24(c.tx);
          qy[wr_ptr] = sext24(c.ty);
          qkx[wr_ptr] = c.kx;
          qky[wr_ptr] = c.ky;
          qdur[wr_ptr] = c.dur;
          qanim[wr_ptr] = c.anim;
          wr_ptr = next_slot(wr_ptr);
          held++;
        end
      end
      FN_TICK: begin
        prv_x = nxt_x;
        prv_y = nxt_y;
        if (acting && held > 0) begin
          e = longint'(elapsed_us) + c.delta;
          if (e > 64'hFFFFFF) e = 64'hFFFFFF;
          elapsed_us = int'(e);
          if (qdur[rd_ptr] == 0 || elapsed_us >= qdur[rd_ptr]) p = 65536;
          else p = (longint'(elapsed_us) << 16) / qdur[rd_ptr];
          nxt_x = pos_x + scale_frac(qx[rd_ptr] - pos_x, p);
          nxt_y = pos_y + scale_frac(qy[rd_ptr] - pos_y, p);
          if (elapsed_us >= qdur[rd_ptr]) begin
            pos_x = qx[rd_ptr];
            nxt_x = pos_x;
            pos_y = qy[rd_ptr];
            nxt_y = pos_y;
            acting = 0;
            pop_head();
          end
        end else if (acting) begin
          acting = 0;
        end else if (held > 0) begin
          start_head();
          acting = 1;
          elapsed_us = 0;
        end
        ox = nxt_x;
        oy = nxt_y;
      end
      FN_SKIP: begin
        acting = 0;
        elapsed_us = 0;
        while (held > 0) begin
          start_head();
          pos_x = qx[rd_ptr];
          nxt_x = pos_x;
          pos_y = qy[rd_ptr];
          nxt_y = pos_y;
          pop_head();
        end
        prv_x = nxt_x;
        prv_y = nxt_y;
        ox = nxt_x;
        oy = nxt_y;
      end
      FN_RENDER: begin
        f = (c.frac > FRAC_ONE) ? 65536 : c.frac;
        ox = prv_x + scale_frac(nxt_x - prv_x, f);
        oy = prv_y + scale_frac(nxt_y - prv_y, f);
      end
      FN_SYNC: begin
        prv_x = nxt_x;
        prv_y = nxt_y;
      end
      default: ;
    endcase
    r.x = ox[23:0];
    r.y = oy[23:0];
    r.anim = anim_now;
    r.busy = acting;
    r.drop = drop;
    r.cnt = held[4:0];
  endtask

  function automatic move_cmd_t mk(logic [2:0] fn, longint tx, longint ty, int unsigned kx,
                                   int unsigned ky, int unsigned dur, int unsigned anim,
                                   int unsigned delta, int unsigned frac);
    move_cmd_t c;
    c.fn = fn;
    c.tx = tx[23:0];
    c.ty = ty[23:0];
    c.kx = kx[0];
    c.ky = ky[0];
    c.dur = dur[23:0];
    c.anim = anim[7:0];
    c.delta = delta[19:0];
    c.frac = frac[16:0];
    return c;
  endfunction

  function automatic move_res_t lit(longint x, longint y, int unsigned anim, bit busy,
                                    bit drop, int unsigned cnt);
    move_res_t r;
    r.x = x[23:0];
    r.y = y[23:0];
    r.anim = anim[7:0];
    r.busy = busy;
    r.drop = drop;
    r.cnt = cnt[4:0];
    return r;
  endfunction

  // offer one word, wait for it to be taken, then hold off between bursts
  task automatic send_move(input move_cmd_t c, input bit use_lit, input move_res_t lit_res);
    move_res_t r;
    s_tdata = {1'b0, c.frac, c.delta, c.anim, c.dur, c.ky, c.kx, c.ty, c.tx};
    s_tuser = c.fn;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_move(c, r);
    expected_moves.push_back(use_lit ? lit_res : r);
    @(negedge clk);
    if (no_gaps) return;
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_plain(input move_cmd_t c);
    send_move(c, 1'b0, lit(0, 0, 0, 0, 0, 0));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input longint value);
    cfg_addr = idx;
    cfg_data = value[23:0];
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_START_X) begin
      pos_x = value; nxt_x = value; prv_x = value;
    end else begin
      pos_y = value; nxt_y = value; prv_y = value;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let every expected word arrive and the block fall quiet
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (expected_moves.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic longint rand_pos();
    return sext24(24'($urandom));
  endfunction

  function automatic move_cmd_t rand_move();
    int unsigned sel;
    int unsigned dur, delta;
    longint tx, ty;
    sel = $urandom_range(0, 99);
    tx = ($urandom_range(0, 3) == 0) ? rand_pos() : sext24(24'($urandom_range(0, 8191) - 4096));
    ty = ($urandom_range(0, 3) == 0) ? rand_pos() : sext24(24'($urandom_range(0, 8191) - 4096));
    case ($urandom_range(0, 9))
      0: dur = 0;
      1: dur = $urandom & 24'hFFFFFF;
      default: dur = $urandom_range(1, 3000);
    endcase
    delta = ($urandom_range(0, 9) == 0) ? ($urandom & 20'hFFFFF) : $urandom_range(0, 800);
    if (sel < 33)
      return mk(FN_PUSH, tx, ty, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                dur, $urandom_range(0, 255), $urandom, $urandom);
    if (sel < 78)
      return mk(FN_TICK, tx, ty, $urandom, $urandom, $urandom, $urandom, delta, $urandom);
    if (sel < 81)
      return mk(FN_SKIP, tx, ty, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (sel < 94)
      return mk(FN_RENDER, tx, ty, $urandom, $urandom, $urandom, $urandom, $urandom,
                ($urandom_range(0, 7) == 0) ? $urandom_range(65536, 131071)
                                            : $urandom_range(0, 65536));
    if (sel < 98)
      return mk(FN_SYNC, tx, ty, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    return mk(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), tx, ty, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endfunction

  // receiver: long hold-offs on request, otherwise a shifting stall pattern
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      case ((cycles / 97) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= (cycles % 3) == 0;
        2: m_tready <= $urandom_range(0, 1);
        default: m_tready <= $urandom_range(0, 7) != 0;
      endcase
    end
  end

  // compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    move_res_t want;
    logic [OUT_W-1:0] got;
    logic [OUT_W-1:0] want_word;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_moves.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        want = expected_moves.pop_front();
        want_word = {1'b0, want.cnt, want.drop, want.busy, want.anim, want.y, want.x};
        if (got[62:0] !== want_word[62:0]) begin
          errors++;
          $display("%0t: expected %h, got %h", $time, want_word, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int n;
    pos_x = 0; pos_y = 0; nxt_x = 0; nxt_y = 0; prv_x = 0; prv_y = 0;
    rd_ptr = 0; wr_ptr = 0; held = 0; elapsed_us = 0; acting = 0; anim_now = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows, literal results where the answer is obvious
    row.lit = 1;
    row.cmd = mk(FN_RENDER, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = lit(0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 0);
    row.res = lit(0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_PUSH, P_MAX, P_MIN, 0, 0, 0, 255, 0, 0);
    row.res = lit(0, 0, 0, 0, 0, 1); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = lit(0, 0, 255, 1, 0, 1); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = lit(P_MAX, P_MIN, 255, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_RENDER, 0, 0, 0, 0, 0, 0, 0, 17'h1FFFF);
    row.res = lit(P_MAX, P_MIN, 255, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_RENDER, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = lit(0, 0, 255, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = lit(P_MAX, P_MIN, 255, 0, 0, 0); rows.push_back(row);
    row.lit = 0;
    row.cmd = mk(FN_SYNC, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_PUSH, P_MIN, P_MAX, 1, 0, 1000, 1, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_PUSH, 1234, -5678, 0, 1, 24'hFFFFFF, 2, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_PUSH, -300, 700, 1, 1, 500, 3, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 333, 0); rows.push_back(row);
    row.cmd = mk(FN_RENDER, 0, 0, 0, 0, 0, 0, 0, 32768); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 0); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_TICK, 0, 0, 0, 0, 0, 0, 1, 0); rows.push_back(row);
    row.cmd = mk(FN_RENDER, 0, 0, 0, 0, 0, 0, 0, 65535); rows.push_back(row);
    row.cmd = mk(FN_SKIP, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_SKIP, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(row);
    row.cmd = mk(FN_SPARE_HI, -1, -1, 1, 1, 24'hFFFFFF, 255, 20'hFFFFF, 17'h1FFFF);
    rows.push_back(row);
    foreach (rows[i]) send_move(rows[i].cmd, rows[i].lit, rows[i].res);
    wait_idle();

    // elapsed time saturating on the longest action
    write_reg(CFG_START_X, P_MAX);
    write_reg(CFG_START_Y, P_MIN);
    send_plain(mk(FN_PUSH, P_MIN, P_MAX, 0, 0, 24'hFFFFFF, 77, 0, 0));
    repeat (19) send_plain(mk(FN_TICK, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 0));
    wait_idle();

    // fill the queue while the output is held off, then drain by skip
    write_reg(CFG_START_X, P_MIN);
    write_reg(CFG_START_Y, P_MAX);
    hold_cycles = 600;
    no_gaps = 1;
    for (int i = 0; i < 20; i++)
      send_plain(mk(FN_PUSH, rand_pos(), rand_pos(), $urandom, $urandom,
                    $urandom_range(0, 5000), $urandom, 0, 0));
    no_gaps = 0;
    send_plain(mk(FN_RENDER, 0, 0, 0, 0, 0, 0, 0, 40000));
    send_plain(mk(FN_SKIP, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // random phases, each with its own start position
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_START_X, (ph == 0) ? 0 : rand_pos());
      write_reg(CFG_START_Y, (ph == 0) ? 0 : rand_pos());
      no_gaps = (ph == 2);
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_plain(rand_move());
      wait_idle();
    end

    if (errors == 0 && expected_moves.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
